// ===== hdl/led_effect_mode_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer assertion macros
// Shared property wrappers for the sequencer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LED_EFFECT_MODE_SEQUENCER_ASSERT_SVH
`define LED_EFFECT_MODE_SEQUENCER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define LES_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/les_pkg.sv =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer package
// Shared types, register map, mode codes and reset values.
// ----------------------------------------------------------------------------
package les_pkg;

  // APB port geometry: seven registers at 4-byte spacing
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;

  // Register indexes
  typedef enum logic [2:0] {
    REG_DIM_LEVEL     = 3'd0,
    REG_BRIGHT_LEVEL  = 3'd1,
    REG_FLASH_LEVEL   = 3'd2,
    REG_HEAD_ON_LEVEL = 3'd3,
    REG_HEAD_OFF_LVL  = 3'd4,
    REG_ADVANCE_TICKS = 3'd5,
    REG_HOME_TICKS    = 3'd6,
    REG_UNUSED        = 3'd7
  } les_reg_e;

  // Register reset values
  localparam logic [15:0] DIM_LEVEL_RST     = 16'd50;
  localparam logic [15:0] BRIGHT_LEVEL_RST  = 16'hFE00;
  localparam logic [15:0] FLASH_LEVEL_RST   = 16'hFF40;
  localparam logic [15:0] HEAD_ON_RST       = 16'h30A0;
  localparam logic [15:0] HEAD_OFF_RST      = 16'h0030;
  localparam logic [7:0]  ADVANCE_TICKS_RST = 8'd10;
  localparam logic [7:0]  HOME_TICKS_RST    = 8'd140;

  // Mode codes
  localparam logic [3:0] MODE_OFF       = 4'd0;
  localparam logic [3:0] MODE_ALL_ON    = 4'd1;
  localparam logic [3:0] MODE_RED       = 4'd2;
  localparam logic [3:0] MODE_GREEN     = 4'd3;
  localparam logic [3:0] MODE_BLUE      = 4'd4;
  localparam logic [3:0] MODE_SWEEP     = 4'd5;
  localparam logic [3:0] MODE_COLOR_CHG = 4'd6;
  localparam logic [3:0] MODE_POLICE    = 4'd7;
  localparam logic [3:0] MODE_STROBE    = 4'd8;
  localparam logic [3:0] MODE_STROBE2   = 4'd9;
  localparam logic [3:0] MODE_RANDOM    = 4'd10;
  localparam logic [3:0] MODE_CHASE     = 4'd11;

  // Duty state reset values
  localparam logic [15:0] COLOR_RST = 16'h2FFF;
  localparam logic [15:0] HEAD_RST  = 16'd32000;

  // Configuration bundle
  typedef struct packed {
    logic [15:0] dim_level;
    logic [15:0] bright_level;
    logic [15:0] flash_level;
    logic [15:0] headlight_on_level;
    logic [15:0] headlight_off_level;
    logic [7:0]  advance_ticks;
    logic [7:0]  home_ticks;
  } les_cfg_t;

  // One result item
  typedef struct packed {
    logic [15:0] red_duty;
    logic [15:0] green_duty;
    logic [15:0] blue_duty;
    logic [15:0] headlight_duty;
    logic [3:0]  mode_now;
    logic        status_lamp;
  } les_result_t;

endpackage

// ===== hdl/les_stream_if.sv =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer stream interfaces
// Valid/ready channels for poll ticks in and duty results out.
// ----------------------------------------------------------------------------
interface les_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_level;
  logic [7:0] timer_byte;

  modport source (output valid, output rx_level, output timer_byte, input ready);
  modport sink   (input valid, input rx_level, input timer_byte, output ready);
endinterface

interface les_duty_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_duty;
  logic [15:0] green_duty;
  logic [15:0] blue_duty;
  logic [15:0] headlight_duty;
  logic [3:0]  mode_now;
  logic        status_lamp;

  modport source (output valid, output red_duty, output green_duty, output blue_duty,
                  output headlight_duty, output mode_now, output status_lamp,
                  input ready);
  modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                  input headlight_duty, input mode_now, input status_lamp,
                  output ready);
endinterface

// ===== hdl/led_effect_mode_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer
// Poll ticks in, RGB and headlight duty values out, with APB configuration.
// ----------------------------------------------------------------------------
// Each accepted tick yields exactly one result. A tick can be accepted every
// clock cycle while duty_out.ready stays high; the tick is held in the input
// register and its result in the result register. Mode, low-tick count,
// pattern counter and duty values update as the tick moves into the result
// register. The input register accepts a new tick while a finished result
// waits in the result register. Registers sit at byte addresses 0 to 24 in
// steps of four and may be written only while no tick is in flight.
`include "led_effect_mode_sequencer_assert.svh"

module led_effect_mode_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  les_tick_if.sink                      tick_in,
  les_duty_if.source                    duty_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [les_pkg::ApbAddrW-1:0]  paddr,
  input  logic [les_pkg::ApbDataW-1:0]  pwdata,
  output logic [les_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import les_pkg::*;

  les_cfg_t    cfg;
  les_result_t core_res;
  les_result_t res_q;
  logic        in_valid_q, out_valid_q;
  logic        rx_q;
  logic [7:0]  timer_q;
  logic        in_acc, advance;

  les_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  les_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .rx_level_i   (rx_q),
    .timer_byte_i (timer_q),
    .cfg_i        (cfg),
    .result_o     (core_res)
  );

  // Move the held tick forward when the result register frees up
  assign advance       = in_valid_q && (!out_valid_q || duty_out.ready);
  assign tick_in.ready = !in_valid_q || advance;
  assign in_acc        = tick_in.valid && tick_in.ready;

  // Hold control state of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (duty_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rx_q    <= tick_in.rx_level;
      timer_q <= tick_in.timer_byte;
    end
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign duty_out.valid          = out_valid_q;
  assign duty_out.red_duty       = res_q.red_duty;
  assign duty_out.green_duty     = res_q.green_duty;
  assign duty_out.blue_duty      = res_q.blue_duty;
  assign duty_out.headlight_duty = res_q.headlight_duty;
  assign duty_out.mode_now       = res_q.mode_now;
  assign duty_out.status_lamp    = res_q.status_lamp;

  `LES_ASSERT_SAME(a_mode_range, clk_i, rst_ni, out_valid_q, res_q.mode_now <= MODE_CHASE, "mode out of range")
  `LES_ASSERT_NEXT(a_adv_fills, clk_i, rst_ni, advance, out_valid_q, "result register not filled")
  `LES_ASSERT_NEXT(a_drain, clk_i, rst_ni, out_valid_q && duty_out.ready && !advance, !out_valid_q, "result not dropped after take")
  `LES_ASSERT_NEXT(a_hold_tick, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(timer_q) && $stable(rx_q), "held tick lost")

endmodule

// ===== hdl/les_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer configuration registers
// APB register file holding duty levels and tick thresholds.
// ----------------------------------------------------------------------------
module les_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [les_pkg::ApbAddrW-1:0]   paddr,
  input  logic [les_pkg::ApbDataW-1:0]   pwdata,
  output logic [les_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output les_pkg::les_cfg_t              cfg_o
);
  import les_pkg::*;

  les_cfg_t cfg_q;
  les_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = les_reg_e'(paddr[ApbAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_level           <= DIM_LEVEL_RST;
      cfg_q.bright_level        <= BRIGHT_LEVEL_RST;
      cfg_q.flash_level         <= FLASH_LEVEL_RST;
      cfg_q.headlight_on_level  <= HEAD_ON_RST;
      cfg_q.headlight_off_level <= HEAD_OFF_RST;
      cfg_q.advance_ticks       <= ADVANCE_TICKS_RST;
      cfg_q.home_ticks          <= HOME_TICKS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DIM_LEVEL:     cfg_q.dim_level           <= pwdata[15:0];
        REG_BRIGHT_LEVEL:  cfg_q.bright_level        <= pwdata[15:0];
        REG_FLASH_LEVEL:   cfg_q.flash_level         <= pwdata[15:0];
        REG_HEAD_ON_LEVEL: cfg_q.headlight_on_level  <= pwdata[15:0];
        REG_HEAD_OFF_LVL:  cfg_q.headlight_off_level <= pwdata[15:0];
        REG_ADVANCE_TICKS: cfg_q.advance_ticks       <= pwdata[7:0];
        REG_HOME_TICKS:    cfg_q.home_ticks          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    case (reg_sel)
      REG_DIM_LEVEL:     prdata = {16'd0, cfg_q.dim_level};
      REG_BRIGHT_LEVEL:  prdata = {16'd0, cfg_q.bright_level};
      REG_FLASH_LEVEL:   prdata = {16'd0, cfg_q.flash_level};
      REG_HEAD_ON_LEVEL: prdata = {16'd0, cfg_q.headlight_on_level};
      REG_HEAD_OFF_LVL:  prdata = {16'd0, cfg_q.headlight_off_level};
      REG_ADVANCE_TICKS: prdata = {24'd0, cfg_q.advance_ticks};
      REG_HOME_TICKS:    prdata = {24'd0, cfg_q.home_ticks};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/les_core.sv =====
// ----------------------------------------------------------------------------
// LED effect mode sequencer core
// Mode selection from the low-tick count and per-mode duty patterns.
// ----------------------------------------------------------------------------
module les_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  rx_level_i,
  input  logic [7:0]            timer_byte_i,
  input  les_pkg::les_cfg_t     cfg_i,
  output les_pkg::les_result_t  result_o
);
  import les_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic        down;
  } les_sweep_t;

  // One step of a triangle sweep channel
  function automatic les_sweep_t sweep_step(input logic [15:0] v, input logic down,
                                            input logic [15:0] stp,
                                            input logic [15:0] top,
                                            input logic [15:0] bottom);
    les_sweep_t r;
    r.value = down ? (v - stp) : (v + stp);
    r.down  = down;
    if (!down && (r.value > top)) begin
      r.down = 1'b1;
    end
    if (r.down && (r.value < bottom)) begin
      r.down = 1'b0;
    end
    return r;
  endfunction

  logic [7:0]  low_ticks_q, low_ticks_d;
  logic [3:0]  mode_q, mode_d, mode_tmp;
  logic [7:0]  count_q, count_d, cnt_base, cnt_inc;
  logic [15:0] red_q, red_d, green_q, green_d, blue_q, blue_d, head_q, head_d;
  logic [2:0]  down_q, down_d;
  les_sweep_t  sw_red, sw_green, sw_blue;

  // Residues of the timer byte for the random mode
  logic [3:0]  mod3_sum;
  logic [4:0]  mod5_sum, mod7_sum;
  logic        div4, div5, div6, div7;

  assign mod3_sum = {2'b0, timer_byte_i[1:0]} + {2'b0, timer_byte_i[3:2]}
                  + {2'b0, timer_byte_i[5:4]} + {2'b0, timer_byte_i[7:6]};
  assign mod5_sum = {1'b0, timer_byte_i[3:0]} + {1'b0, timer_byte_i[7:4]};
  assign mod7_sum = {2'b0, timer_byte_i[2:0]} + {2'b0, timer_byte_i[5:3]}
                  + {3'b0, timer_byte_i[7:6]};
  assign div4 = (timer_byte_i[1:0] == 2'd0);
  assign div5 = mod5_sum inside {5'd0, 5'd5, 5'd10, 5'd15, 5'd20, 5'd25, 5'd30};
  assign div6 = !timer_byte_i[0] && (mod3_sum inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12});
  assign div7 = mod7_sum inside {5'd0, 5'd7, 5'd14};

  assign sw_red   = sweep_step(red_q,   down_q[0], 16'd257, 16'h8000, 16'd320);
  assign sw_green = sweep_step(green_q, down_q[1], 16'd491, 16'h8000, 16'd550);
  assign sw_blue  = sweep_step(blue_q,  down_q[2], 16'd107, 16'hFE00, 16'd170);

  // Count low ticks and pick the mode
  always_comb begin
    mode_tmp = mode_q;
    if (rx_level_i) begin
      low_ticks_d = '0;
      if (low_ticks_q > cfg_i.advance_ticks) begin
        mode_tmp = mode_q + 4'd1;
        if (low_ticks_q > cfg_i.home_ticks) begin
          mode_tmp = MODE_OFF;
        end
      end
    end else if (low_ticks_q != 8'hFF) begin
      low_ticks_d = low_ticks_q + 8'd1;
    end else begin
      low_ticks_d = low_ticks_q;
    end
    mode_d = (mode_tmp > MODE_CHASE) ? MODE_ALL_ON : mode_tmp;
  end

  // Apply the pattern of the selected mode
  always_comb begin
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    head_d   = head_q;
    down_d   = down_q;
    count_d  = count_q;
    cnt_base = count_q;
    cnt_inc  = count_q + 8'd1;
    case (mode_d)
      MODE_OFF: begin
        red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
        head_d = cfg_i.headlight_off_level;
      end
      MODE_ALL_ON: begin
        red_d = cfg_i.bright_level; green_d = cfg_i.bright_level;
        blue_d = cfg_i.bright_level;
        head_d = cfg_i.headlight_on_level;
      end
      MODE_RED: begin
        red_d = cfg_i.bright_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
        head_d = cfg_i.headlight_off_level;
      end
      MODE_GREEN: begin
        red_d = cfg_i.dim_level; green_d = cfg_i.bright_level; blue_d = cfg_i.dim_level;
        head_d = cfg_i.headlight_off_level;
      end
      MODE_BLUE: begin
        red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.bright_level;
        head_d = cfg_i.headlight_off_level;
      end
      MODE_SWEEP: begin
        red_d   = sw_red.value;
        green_d = sw_green.value;
        blue_d  = sw_blue.value;
        down_d  = {sw_blue.down, sw_green.down, sw_red.down};
      end
      MODE_COLOR_CHG: begin
        cnt_base = count_q[7] ? 8'd0 : count_q;
        red_d   = cnt_base[4] ? cfg_i.bright_level : cfg_i.dim_level;
        green_d = cnt_base[6] ? cfg_i.bright_level : cfg_i.dim_level;
        blue_d  = cnt_base[5] ? cfg_i.bright_level : cfg_i.dim_level;
        head_d  = cfg_i.headlight_off_level;
        count_d = cnt_base + 8'd1;
      end
      MODE_POLICE: begin
        if (count_q == 8'd0 || count_q == 8'd6) begin
          red_d = cfg_i.bright_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
        end
        if (count_q == 8'd24 || count_q == 8'd30) begin
          red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.bright_level;
        end
        if (count_q inside {8'd4, 8'd10, 8'd28, 8'd34}) begin
          red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
        end
        count_d = (cnt_inc > 8'd48) ? 8'd0 : cnt_inc;
      end
      MODE_STROBE: begin
        cnt_base = (count_q > 8'd3) ? 8'd0 : count_q;
        if (cnt_base == 8'd0) begin
          red_d = cfg_i.flash_level; green_d = cfg_i.flash_level;
          blue_d = cfg_i.flash_level;
          head_d = cfg_i.headlight_on_level;
        end else begin
          red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
          head_d = cfg_i.headlight_off_level;
        end
        count_d = cnt_base + 8'd1;
      end
      MODE_STROBE2: begin
        cnt_base = (count_q > 8'd15) ? 8'd0 : count_q;
        red_d   = (cnt_base == 8'd0 || cnt_base == 8'd8) ? cfg_i.flash_level
                                                         : cfg_i.dim_level;
        green_d = (cnt_base == 8'd0 || cnt_base == 8'd12) ? cfg_i.flash_level
                                                          : cfg_i.dim_level;
        blue_d  = (cnt_base == 8'd0 || cnt_base == 8'd4) ? cfg_i.flash_level
                                                         : cfg_i.dim_level;
        head_d  = (cnt_base == 8'd0) ? cfg_i.headlight_on_level
                                     : cfg_i.headlight_off_level;
        count_d = cnt_base + 8'd1;
      end
      MODE_RANDOM: begin
        if (timer_byte_i[0]) begin
          red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
          head_d = cfg_i.headlight_off_level;
        end else begin
          red_d   = div4 ? cfg_i.flash_level : cfg_i.dim_level;
          green_d = div5 ? cfg_i.flash_level : cfg_i.dim_level;
          blue_d  = div6 ? cfg_i.flash_level : cfg_i.dim_level;
          head_d  = div7 ? cfg_i.headlight_on_level : cfg_i.headlight_off_level;
        end
      end
      default: begin
        // Chase: ten ticks per colour
        if (count_q < 8'd10) begin
          red_d = cfg_i.bright_level; green_d = cfg_i.dim_level; blue_d = cfg_i.dim_level;
        end else if (count_q < 8'd20) begin
          red_d = cfg_i.dim_level; green_d = cfg_i.bright_level; blue_d = cfg_i.dim_level;
        end else begin
          red_d = cfg_i.dim_level; green_d = cfg_i.dim_level; blue_d = cfg_i.bright_level;
        end
        count_d = (cnt_inc > 8'd29) ? 8'd0 : cnt_inc;
      end
    endcase
  end

  // Advance the state once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_ticks_q <= '0;
      mode_q      <= MODE_OFF;
      count_q     <= '0;
      red_q       <= COLOR_RST;
      green_q     <= COLOR_RST;
      blue_q      <= COLOR_RST;
      head_q      <= HEAD_RST;
      down_q      <= '0;
    end else if (step_i) begin
      low_ticks_q <= low_ticks_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      head_q      <= head_d;
      down_q      <= down_d;
    end
  end

  assign result_o.red_duty       = red_d;
  assign result_o.green_duty     = green_d;
  assign result_o.blue_duty      = blue_d;
  assign result_o.headlight_duty = head_d;
  assign result_o.mode_now       = mode_d;
  assign result_o.status_lamp    = rx_level_i;

endmodule

// ===== sim/les_duty_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED effect sequencer duty checker
// Watches the tick and duty channels and the APB write port, keeps its own
// model of the mode, pattern and duty state, and compares every duty result
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module les_duty_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  les_tick_if                          tick,
  les_duty_if                          duty,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [les_pkg::ApbAddrW-1:0] paddr,
  input  logic [les_pkg::ApbDataW-1:0] pwdata,
  output int unsigned                  mismatches_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  results_o,
  output logic [11:0]                  modes_seen_o
);
  import les_pkg::*;

  // Triangle sweep steps and turning points
  localparam logic [15:0] BlueStride   = 16'd107;
  localparam logic [15:0] RedStride    = 16'd257;
  localparam logic [15:0] GreenStride  = 16'd491;
  localparam logic [15:0] BlueTurnDown = 16'hFE00;
  localparam logic [15:0] RgTurnDown   = 16'h8000;
  localparam logic [15:0] BlueTurnUp   = 16'd170;
  localparam logic [15:0] RedTurnUp    = 16'd320;
  localparam logic [15:0] GreenTurnUp  = 16'd550;

  les_cfg_t    levels;
  logic [7:0]  low_run;
  logic [7:0]  beat;
  logic [3:0]  cur_mode;
  logic [15:0] red_v, green_v, blue_v, head_v;
  logic [2:0]  falling;

  les_result_t predicted_duty[$];
  les_result_t got, want, fresh;
  int unsigned fails;
  int unsigned results;
  logic [11:0] modes_seen;

  assign mismatches_o = fails;
  assign results_o    = results;
  assign modes_seen_o = modes_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] duty check: %s", $time, what);
    fails++;
  endtask

  function automatic void paint(input logic [15:0] r, input logic [15:0] g,
                                input logic [15:0] b);
    red_v   = r;
    green_v = g;
    blue_v  = b;
  endfunction

  function automatic void light_head(input logic on_lvl);
    head_v = on_lvl ? levels.headlight_on_level : levels.headlight_off_level;
  endfunction

  // Step one channel of the triangle sweep and flip its direction at the ends
  function automatic logic [15:0] sweep_channel(input logic [15:0] v, input int unsigned ch,
                                                input logic [15:0] stride,
                                                input logic [15:0] turn_down,
                                                input logic [15:0] turn_up);
    logic [15:0] nv;
    nv = falling[ch] ? v - stride : v + stride;
    if (!falling[ch] && nv > turn_down) falling[ch] = 1'b1;
    if (falling[ch] && nv < turn_up) falling[ch] = 1'b0;
    return nv;
  endfunction

  // Advance the mode and pattern state by one tick and build its duty result
  task automatic advance_lighting(input logic rx, input logic [7:0] tb,
                                  output les_result_t res);
    logic [15:0] dl, bl, fl;
    logic [7:0]  c;
    dl = levels.dim_level;
    bl = levels.bright_level;
    fl = levels.flash_level;
    if (rx) begin
      if (low_run > levels.advance_ticks) begin
        cur_mode = cur_mode + 4'd1;
        if (low_run > levels.home_ticks) cur_mode = MODE_OFF;
      end
      low_run = '0;
    end else if (low_run != 8'hFF) begin
      low_run = low_run + 8'd1;
    end
    if (cur_mode > MODE_CHASE) cur_mode = MODE_ALL_ON;

    case (cur_mode)
      MODE_OFF: begin
        paint(dl, dl, dl);
        light_head(1'b0);
      end
      MODE_ALL_ON: begin
        paint(bl, bl, bl);
        light_head(1'b1);
      end
      MODE_RED: begin
        paint(bl, dl, dl);
        light_head(1'b0);
      end
      MODE_GREEN: begin
        paint(dl, bl, dl);
        light_head(1'b0);
      end
      MODE_BLUE: begin
        paint(dl, dl, bl);
        light_head(1'b0);
      end
      MODE_SWEEP: begin
        blue_v  = sweep_channel(blue_v, 2, BlueStride, BlueTurnDown, BlueTurnUp);
        red_v   = sweep_channel(red_v, 0, RedStride, RgTurnDown, RedTurnUp);
        green_v = sweep_channel(green_v, 1, GreenStride, RgTurnDown, GreenTurnUp);
      end
      MODE_COLOR_CHG: begin
        if (beat > 8'd127) beat = '0;
        paint(beat[4] ? bl : dl, beat[6] ? bl : dl, beat[5] ? bl : dl);
        light_head(1'b0);
        beat = beat + 8'd1;
      end
      MODE_POLICE: begin
        c = beat;
        if (c == 8'd0 || c == 8'd6) paint(bl, dl, dl);
        if (c == 8'd24 || c == 8'd30) paint(dl, dl, bl);
        if (c inside {8'd4, 8'd10, 8'd28, 8'd34}) paint(dl, dl, dl);
        beat = c + 8'd1;
        if (beat > 8'd48) beat = '0;
      end
      MODE_STROBE: begin
        if (beat > 8'd3) beat = '0;
        if (beat == 8'd0) begin
          paint(fl, fl, fl);
          light_head(1'b1);
        end else begin
          paint(dl, dl, dl);
          light_head(1'b0);
        end
        beat = beat + 8'd1;
      end
      MODE_STROBE2: begin
        if (beat > 8'd15) beat = '0;
        c = beat;
        if (c == 8'd0) paint(fl, fl, fl);
        else if (c == 8'd4) paint(dl, dl, fl);
        else if (c == 8'd8) paint(fl, dl, dl);
        else if (c == 8'd12) paint(dl, fl, dl);
        else paint(dl, dl, dl);
        light_head(c == 8'd0);
        beat = c + 8'd1;
      end
      MODE_RANDOM: begin
        if (tb[0]) begin
          light_head(1'b0);
          paint(dl, dl, dl);
        end else begin
          paint((tb % 4 == 0) ? fl : dl, (tb % 5 == 0) ? fl : dl, (tb % 6 == 0) ? fl : dl);
          light_head(tb % 7 == 0);
        end
      end
      default: begin
        if (beat < 8'd10) paint(bl, dl, dl);
        else if (beat < 8'd20) paint(dl, bl, dl);
        else paint(dl, dl, bl);
        beat = beat + 8'd1;
        if (beat > 8'd29) beat = '0;
      end
    endcase

    res = '{red_v, green_v, blue_v, head_v, cur_mode, rx};
  endtask

  // Track register writes, check results, predict accepted ticks
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels        = '{DIM_LEVEL_RST, BRIGHT_LEVEL_RST, FLASH_LEVEL_RST, HEAD_ON_RST,
                        HEAD_OFF_RST, ADVANCE_TICKS_RST, HOME_TICKS_RST};
      low_run       = '0;
      beat          = '0;
      cur_mode      = MODE_OFF;
      red_v         = COLOR_RST;
      green_v       = COLOR_RST;
      blue_v        = COLOR_RST;
      head_v        = HEAD_RST;
      falling       = '0;
      fails         = 0;
      results       = 0;
      modes_seen    = '0;
      predicted_duty.delete();
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (les_reg_e'(paddr[4:2]))
          REG_DIM_LEVEL:     levels.dim_level           = pwdata[15:0];
          REG_BRIGHT_LEVEL:  levels.bright_level        = pwdata[15:0];
          REG_FLASH_LEVEL:   levels.flash_level         = pwdata[15:0];
          REG_HEAD_ON_LEVEL: levels.headlight_on_level  = pwdata[15:0];
          REG_HEAD_OFF_LVL:  levels.headlight_off_level = pwdata[15:0];
          REG_ADVANCE_TICKS: levels.advance_ticks       = pwdata[7:0];
          REG_HOME_TICKS:    levels.home_ticks          = pwdata[7:0];
          default: ;
        endcase
      end

      if (duty.valid && duty.ready) begin
        got = '{duty.red_duty, duty.green_duty, duty.blue_duty, duty.headlight_duty,
                duty.mode_now, duty.status_lamp};
        results++;
        if (predicted_duty.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no tick outstanding", results));
        end else begin
          want = predicted_duty.pop_front();
          if (want.mode_now <= MODE_CHASE) modes_seen[want.mode_now] = 1'b1;
          if (got.red_duty !== want.red_duty)
            report_mismatch($sformatf("result %0d red_duty %0h, expected %0h",
                                      results, got.red_duty, want.red_duty));
          if (got.green_duty !== want.green_duty)
            report_mismatch($sformatf("result %0d green_duty %0h, expected %0h",
                                      results, got.green_duty, want.green_duty));
          if (got.blue_duty !== want.blue_duty)
            report_mismatch($sformatf("result %0d blue_duty %0h, expected %0h",
                                      results, got.blue_duty, want.blue_duty));
          if (got.headlight_duty !== want.headlight_duty)
            report_mismatch($sformatf("result %0d headlight_duty %0h, expected %0h",
                                      results, got.headlight_duty, want.headlight_duty));
          if (got.mode_now !== want.mode_now)
            report_mismatch($sformatf("result %0d mode_now %0d, expected %0d",
                                      results, got.mode_now, want.mode_now));
          if (got.status_lamp !== want.status_lamp)
            report_mismatch($sformatf("result %0d status_lamp %0b, expected %0b",
                                      results, got.status_lamp, want.status_lamp));
        end
      end

      if (tick.valid && tick.ready) begin
        advance_lighting(tick.rx_level, tick.timer_byte, fresh);
        predicted_duty.push_back(fresh);
      end

      outstanding_o <= predicted_duty.size();
    end
  end

endmodule

// ===== sim/tb_led_effect_mode_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED effect mode sequencer testbench
// Drives poll ticks with random gaps and receiver stalls through several
// register settings, lets the duty checker predict and compare every result,
// and reports the verdict.
// ----------------------------------------------------------------------------
module tb_led_effect_mode_sequencer;
  import les_pkg::*;

  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned DrainLimit     = 5000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic                pready;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;

  les_tick_if tick_ch ();
  les_duty_if duty_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results;
  logic [11:0] modes_seen;

  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned cur_adv;
  int unsigned cur_home;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_off_req;

  led_effect_mode_sequencer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_in  (tick_ch),
    .duty_out (duty_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  les_duty_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick          (tick_ch),
    .duty          (duty_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results),
    .modes_seen_o  (modes_seen)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("** led_effect_mode_sequencer: FAILED **");
    $finish;
  end

  // Duty receiver: random stall bursts, plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    duty_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req) begin
        stall_left   = LongHoldCycles;
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      duty_ch.ready <= (stall_left == 0);
    end
  end

  // Offer one tick and hold it until the block takes it
  task automatic send_tick(input logic rx, input logic [7:0] tb);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.rx_level   <= rx;
    tick_ch.timer_byte <= tb;
    do @(posedge clk_i); while (!tick_ch.ready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic rx, input int unsigned count);
    repeat (count) send_tick(rx, 8'($urandom));
  endtask

  // Drop valid and wait for every predicted result to drain
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    tick_ch.valid <= 1'b0;
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup phase, then access phase until pready
  task automatic write_reg(input les_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write every register; upper data bits carry junk the block must drop
  task automatic load_levels(input logic [15:0] dim, input logic [15:0] bright,
                             input logic [15:0] flash, input logic [15:0] on_lvl,
                             input logic [15:0] off_lvl, input logic [7:0] adv,
                             input logic [7:0] home);
    write_reg(REG_DIM_LEVEL,     {16'($urandom), dim});
    write_reg(REG_BRIGHT_LEVEL,  {16'($urandom), bright});
    write_reg(REG_FLASH_LEVEL,   {16'($urandom), flash});
    write_reg(REG_HEAD_ON_LEVEL, {16'($urandom), on_lvl});
    write_reg(REG_HEAD_OFF_LVL,  {16'($urandom), off_lvl});
    write_reg(REG_ADVANCE_TICKS, {24'($urandom), adv});
    write_reg(REG_HOME_TICKS,    {24'($urandom), home});
    cur_adv  = adv;
    cur_home = home;
    settings_used++;
  endtask

  // One button gesture: advance press, home press, short glitch or noise
  task automatic play_group();
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned highs;
    pick  = $urandom_range(0, 15);
    highs = $urandom_range(1, 50);
    if (pick <= 10) begin
      if (cur_adv >= 255) begin
        lo = 0;
        hi = 20;
      end else begin
        lo = cur_adv + 1;
        hi = (cur_home > cur_adv) ? ((cur_home < cur_adv + 25) ? cur_home : cur_adv + 25)
                                  : lo;
      end
      send_run(1'b0, $urandom_range(lo, hi));
      send_run(1'b1, highs);
    end else if (pick == 11) begin
      lo = cur_home + 1;
      hi = lo + (($urandom_range(0, 3) == 0) ? 160 : 20);
      if (hi > 300) hi = 300;
      send_run(1'b0, $urandom_range(lo, hi));
      send_run(1'b1, highs);
    end else if (pick <= 13) begin
      send_run(1'b0, $urandom_range(0, (cur_adv > 30) ? 30 : cur_adv));
      send_run(1'b1, highs);
    end else begin
      repeat ($urandom_range(1, 10)) send_tick(1'($urandom), 8'($urandom));
    end
  endtask

  // Random gestures until the budget is spent; optional hold or pause midway
  task automatic run_phase(input int unsigned budget, input bit hold_mid,
                           input bit pause_mid, input bit idle_ok);
    int unsigned target;
    int unsigned midpoint;
    bit          marked;
    target   = ticks_sent + budget;
    midpoint = ticks_sent + budget / 2;
    marked   = 1'b0;
    while (ticks_sent < target) begin
      tx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
      rx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
      if (!marked && ticks_sent >= midpoint) begin
        marked = 1'b1;
        if (hold_mid) hold_off_req = 1'b1;
        if (pause_mid) settle_block();
      end
      play_group();
    end
    settle_block();
  endtask

  // Stimulus and verdict
  initial begin
    tick_ch.valid      <= 1'b0;
    tick_ch.rx_level   <= 1'b0;
    tick_ch.timer_byte <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    rst_ni             = 1'b0;
    ticks_sent         = 0;
    settings_used      = 1;
    cur_adv            = ADVANCE_TICKS_RST;
    cur_home           = HOME_TICKS_RST;
    tx_idle_on         = 1'b0;
    rx_idle_on         = 1'b1;
    hold_off_req       = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes, then a press that advances from off to all on
    send_tick(1'b1, 8'h00);
    send_tick(1'b0, 8'hFF);
    send_tick(1'b1, 8'hFF);
    send_tick(1'b0, 8'h00);
    send_run(1'b0, 11);
    send_tick(1'b1, 8'hAA);
    send_tick(1'b1, 8'h55);

    // Reset settings, with one long receiver hold
    run_phase(350, 1'b1, 1'b0, 1'b1);

    // Extremes: zero dim, full bright, advance on any low, never home
    load_levels(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd0, 8'd255);
    write_reg(REG_UNUSED, $urandom);
    run_phase(300, 1'b0, 1'b0, 1'b1);

    // Opposite extremes: advance never possible
    load_levels(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'd255, 8'd0);
    run_phase(120, 1'b0, 1'b0, 1'b1);

    // Random levels and thresholds, sender drains the block midway
    load_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom_range(0, 20)), 8'($urandom_range(0, 200)));
    run_phase(300, 1'b0, 1'b1, 1'b1);

    // Back to reset values, no idling on either side
    load_levels(DIM_LEVEL_RST, BRIGHT_LEVEL_RST, FLASH_LEVEL_RST, HEAD_ON_RST, HEAD_OFF_RST,
                ADVANCE_TICKS_RST, HOME_TICKS_RST);
    run_phase(350, 1'b0, 1'b0, 1'b0);

    settle_block();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d ticks and %0d results over %0d register settings,",
             ticks_sent, results, settings_used);
    $display("reaching %0d of 12 effect modes.", $countones(modes_seen));
    if (mismatches == 0 && outstanding == 0) begin
      $display("** led_effect_mode_sequencer: PASSED **");
    end else begin
      if (outstanding != 0) $display("%0d predicted results never arrived", outstanding);
      $display("** led_effect_mode_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
